### design/wsds_pkg.sv
// Package for the wind speed and direction statistics block.
// Holds ring depths, derived widths, the vane direction table and the sequencer states.
// No dependencies.
package wsds_pkg;

    localparam int SHORT_DEPTH = 120;
    localparam int LONG_DEPTH  = 600;

    localparam int SHORT_AW = $clog2(SHORT_DEPTH);
    localparam int LONG_AW  = $clog2(LONG_DEPTH);
    localparam int SCNT_W   = $clog2(SHORT_DEPTH + 1);
    localparam int LCNT_W   = $clog2(LONG_DEPTH + 1);
    localparam int SCAN_W   = (LCNT_W > SCNT_W) ? LCNT_W : SCNT_W;

    localparam int SPD_W     = 16;
    localparam int DIR_W     = 12;
    localparam int ENTRY_W   = SPD_W + DIR_W;
    localparam int SPD_SUM_W = SPD_W + SCNT_W;
    localparam int DACC_W    = 15;
    localparam int DSUM_W    = DACC_W + SCNT_W;
    localparam int PROD_W    = 39;
    localparam int DIV_W     = (DSUM_W > PROD_W) ? DSUM_W : PROD_W;
    localparam int DCNT_W    = $clog2(DIV_W + 1);

    localparam int SPD_FACTOR = 100;
    localparam int DIR_HALF   = 1800;
    localparam int DIR_FULL   = 3600;
    localparam logic [15:0] SCALE_RESET = 16'd1492;
    localparam logic [1:0]  ADDR_SCALE  = 2'd0;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SCALE, S_DIV_SPD, S_STORE, S_SCAN, S_DRAIN,
        S_MEAN, S_DIV_MEAN, S_DIV_DIR, S_OUT
    } t_state;

    typedef logic [11:0] t_lut16 [16];

    localparam t_lut16 DIR_LIMIT = '{
        12'd273, 12'd345, 12'd382, 12'd516, 12'd748, 12'd989, 12'd1159, 12'd1633,
        12'd1855, 12'd2408, 12'd2530, 12'd2821, 12'd3153, 12'd3320, 12'd3558, 12'd3790
    };
    localparam t_lut16 DIR_VALUE = '{
        12'd1125, 12'd675, 12'd900, 12'd1575, 12'd1350, 12'd2025, 12'd1800, 12'd225,
        12'd450, 12'd2475, 12'd2250, 12'd3375, 12'd3600, 12'd2925, 12'd3150, 12'd2700
    };

    function automatic logic [DIR_W-1:0] vane_dir(input logic [11:0] adc);
        logic [DIR_W-1:0] res;
        res = '0;
        for (int i = 15; i >= 0; i--) begin
            if (adc < DIR_LIMIT[i]) begin
                res = DIR_VALUE[i];
            end
        end
        return res;
    endfunction

endpackage

### design/wind_speed_direction_statistics_top.sv
// Wind speed and direction statistics top level with sequencer, shared divider and rings.
// Depends on wsds_pkg.
// Sample beat: the speed is divided by the elapsed time in the bit-serial shared divider;
// a zero elapsed time skips the divider.
// Report beat: a ring scan over the larger of the short and long fill counts, a drain step,
// the mean step, then two divider runs for mean speed and mean direction and the output step.
// The input is stalled for the whole of each beat's work; output stalls lengthen it.
// Synchronous active-low reset clears control state; rings use fill counts, no clearing pass.
module wind_speed_direction_statistics_top
    import wsds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_req_type,
    input  logic [15:0]         i_pulse_count,
    input  logic [15:0]         i_elapsed_ms,
    input  logic [11:0]         i_vane_adc,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [SPD_W-1:0]    o_instant_speed,
    output logic [DIR_W-1:0]    o_instant_dir,
    output logic [SPD_W-1:0]    o_gust_speed,
    output logic [DIR_W-1:0]    o_gust_dir,
    output logic [SPD_W-1:0]    o_mean_speed,
    output logic [DIR_W-1:0]    o_mean_dir,
    output logic [SPD_W-1:0]    o_peak_speed,
    output logic [DIR_W-1:0]    o_peak_dir
);

    localparam logic signed [DACC_W-1:0] L_HALF = DACC_W'(DIR_HALF);
    localparam logic signed [DACC_W-1:0] L_FULL = DACC_W'(DIR_FULL);

    t_state r_state, n_state;

    logic [15:0]            r_scale;
    logic [15:0]            r_pulse, r_ms;
    logic [11:0]            r_adc;
    logic [31:0]            r_prod;
    logic [PROD_W-1:0]      prod100;
    logic [SPD_W-1:0]       r_spd;

    logic [SPD_W-1:0]       r_now_spd, r_gust_spd;
    logic [DIR_W-1:0]       r_now_dir, r_gust_dir;
    logic [SHORT_AW-1:0]    r_spos;
    logic                   r_sfull;
    logic [LONG_AW-1:0]     r_lpos;
    logic [LCNT_W-1:0]      r_lcnt;

    logic [ENTRY_W-1:0]     short_mem [SHORT_DEPTH];
    logic [ENTRY_W-1:0]     long_mem [LONG_DEPTH];
    logic [ENTRY_W-1:0]     r_short_rd, r_long_rd;

    logic [SCNT_W-1:0]      r_n;
    logic [SCAN_W-1:0]      r_scan_idx, r_rd_idx;
    logic                   r_rd_vld;
    logic [SPD_SUM_W-1:0]   r_total;
    logic signed [DACC_W-1:0] r_dacc;
    logic signed [DSUM_W-1:0] r_dsum;
    logic [SPD_W-1:0]       r_pk_spd, r_mean;
    logic [DIR_W-1:0]       r_pk_dir, r_mdir;

    logic [DIV_W-1:0]       r_dv_num;
    logic [15:0]            r_dv_den, r_dv_rem;
    logic [DCNT_W-1:0]      r_dv_cnt;
    logic                   dv_load;
    logic [DIV_W-1:0]       dv_num_in;
    logic [15:0]            dv_den_in;
    logic                   dv_done;
    logic [16:0]            dv_trial;
    logic                   dv_ge;

    logic [SPD_W-1:0]       r_o_ispd, r_o_gspd, r_o_mspd, r_o_pspd;
    logic [DIR_W-1:0]       r_o_idir, r_o_gdir, r_o_mdir, r_o_pdir;
    logic                   r_out_valid;

    logic                   in_acc, out_free;
    logic [SCNT_W-1:0]      short_cnt;
    logic [SCAN_W-1:0]      scan_len;
    logic [DIR_W-1:0]       new_dir;
    logic [SHORT_AW-1:0]    s_addr;
    logic [LONG_AW-1:0]     l_addr;
    logic                   do_store;
    logic [SPD_W-1:0]       rd_s_spd, rd_l_spd;
    logic [DIR_W-1:0]       rd_s_dir, rd_l_dir;
    logic signed [DACC_W-1:0] rd_dir_x, delta, d_new;
    logic                   dsum_neg;
    logic [DSUM_W-1:0]      dsum_mag;
    logic                   rem_nz;
    logic [12:0]            dq, dmod;

    assign pready     = 1'b1;
    assign prdata     = {16'b0, r_scale};
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign short_cnt = r_sfull ? SCNT_W'(SHORT_DEPTH) : SCNT_W'(r_spos);
    assign scan_len  = (SCAN_W'(r_n) > SCAN_W'(r_lcnt)) ? SCAN_W'(r_n) : SCAN_W'(r_lcnt);
    assign new_dir   = vane_dir(r_adc);
    assign do_store  = (r_state == S_STORE);
    assign s_addr    = do_store ? r_spos : r_scan_idx[SHORT_AW-1:0];
    assign l_addr    = do_store ? r_lpos : r_scan_idx[LONG_AW-1:0];
    assign prod100   = {7'b0, r_prod} * PROD_W'(SPD_FACTOR);

    assign rd_s_spd = r_short_rd[ENTRY_W-1:DIR_W];
    assign rd_s_dir = r_short_rd[DIR_W-1:0];
    assign rd_l_spd = r_long_rd[ENTRY_W-1:DIR_W];
    assign rd_l_dir = r_long_rd[DIR_W-1:0];

    assign rd_dir_x = $signed({{(DACC_W-DIR_W){1'b0}}, rd_s_dir});
    assign delta    = rd_dir_x - r_dacc;
    always_comb begin
        priority if (r_rd_idx == '0) begin
            d_new = rd_dir_x;
        end else if (delta < -L_HALF) begin
            d_new = rd_dir_x + L_FULL;
        end else if (delta > L_HALF) begin
            d_new = rd_dir_x - L_FULL;
        end else begin
            d_new = rd_dir_x;
        end
    end

    assign dsum_neg = r_dsum[DSUM_W-1];
    assign dsum_mag = dsum_neg ? DSUM_W'(-r_dsum) : DSUM_W'(r_dsum);
    assign rem_nz   = (r_dv_rem != '0);

    // Two compares reduce the floored mean's magnitude modulo one turn, for magnitudes below three turns.
    assign dq = 13'(r_dv_num) + 13'(dsum_neg && rem_nz);
    always_comb begin
        priority if (dq >= 13'(2 * DIR_FULL)) begin
            dmod = dq - 13'(2 * DIR_FULL);
        end else if (dq >= 13'(DIR_FULL)) begin
            dmod = dq - 13'(DIR_FULL);
        end else begin
            dmod = dq;
        end
    end

    assign dv_done  = (r_dv_cnt == '0);
    assign dv_trial = {r_dv_rem, r_dv_num[DIV_W-1]};
    assign dv_ge    = (dv_trial >= {1'b0, r_dv_den});

    always_comb begin
        n_state   = r_state;
        dv_load   = 1'b0;
        dv_num_in = '0;
        dv_den_in = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_req_type) begin
                        n_state = S_MUL;
                    end else if (r_lcnt == '0 && short_cnt == '0) begin
                        n_state = S_MEAN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_MUL: n_state = S_SCALE;
            S_SCALE: begin
                if (r_ms == '0) begin
                    n_state = S_STORE;
                end else begin
                    dv_load   = 1'b1;
                    dv_num_in = DIV_W'(prod100);
                    dv_den_in = r_ms;
                    n_state   = S_DIV_SPD;
                end
            end
            S_DIV_SPD: begin
                if (dv_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: n_state = S_IDLE;
            S_SCAN: begin
                if (r_scan_idx + 1'b1 == scan_len) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_MEAN;
            S_MEAN: begin
                if (r_n == '0) begin
                    n_state = S_OUT;
                end else begin
                    dv_load   = 1'b1;
                    dv_num_in = DIV_W'(r_total);
                    dv_den_in = 16'(r_n);
                    n_state   = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN: begin
                if (dv_done) begin
                    dv_load   = 1'b1;
                    dv_num_in = DIV_W'(dsum_mag);
                    dv_den_in = 16'(r_n);
                    n_state   = S_DIV_DIR;
                end
            end
            S_DIV_DIR: begin
                if (dv_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_load) begin
            r_dv_num <= dv_num_in;
            r_dv_den <= dv_den_in;
            r_dv_rem <= '0;
        end else if (!dv_done) begin
            r_dv_num <= {r_dv_num[DIV_W-2:0], dv_ge};
            r_dv_rem <= dv_ge ? 16'(dv_trial - {1'b0, r_dv_den}) : dv_trial[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= '0;
        end else if (dv_load) begin
            r_dv_cnt <= DCNT_W'(DIV_W);
        end else if (!dv_done) begin
            r_dv_cnt <= r_dv_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            short_mem[s_addr] <= {r_spd, new_dir};
        end
        r_short_rd <= short_mem[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            long_mem[l_addr] <= {r_spd, new_dir};
        end
        r_long_rd <= long_mem[l_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_SCALE) begin
            r_scale <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pulse <= i_pulse_count;
            r_ms    <= i_elapsed_ms;
            r_adc   <= i_vane_adc;
        end
        r_prod <= r_pulse * r_scale;
        if (r_state == S_SCALE && r_ms == '0) begin
            r_spd <= '1;
        end else if (r_state == S_DIV_SPD && dv_done) begin
            r_spd <= (|r_dv_num[DIV_W-1:SPD_W]) ? '1 : r_dv_num[SPD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_spd  <= '0;
            r_now_dir  <= '0;
            r_gust_spd <= '0;
            r_gust_dir <= '0;
            r_spos     <= '0;
            r_sfull    <= 1'b0;
            r_lpos     <= '0;
            r_lcnt     <= '0;
        end else if (do_store) begin
            r_now_spd <= r_spd;
            r_now_dir <= new_dir;
            if (r_spd > r_gust_spd) begin
                r_gust_spd <= r_spd;
                r_gust_dir <= new_dir;
            end
            if (r_spos == SHORT_AW'(SHORT_DEPTH - 1)) begin
                r_spos  <= '0;
                r_sfull <= 1'b1;
            end else begin
                r_spos <= r_spos + 1'b1;
            end
            if (r_lpos == LONG_AW'(LONG_DEPTH - 1)) begin
                r_lpos <= '0;
            end else begin
                r_lpos <= r_lpos + 1'b1;
            end
            if (r_lcnt != LCNT_W'(LONG_DEPTH)) begin
                r_lcnt <= r_lcnt + 1'b1;
            end
        end else if (r_state == S_OUT && out_free) begin
            r_now_spd  <= '0;
            r_now_dir  <= '0;
            r_gust_spd <= '0;
            r_gust_dir <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_scan_idx;
        if (in_acc) begin
            r_n        <= short_cnt;
            r_scan_idx <= '0;
            r_total    <= '0;
            r_dsum     <= '0;
            r_dacc     <= '0;
            r_pk_spd   <= '0;
            r_pk_dir   <= '0;
        end else begin
            if (r_state == S_SCAN) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (r_rd_vld) begin
                if (r_rd_idx < SCAN_W'(r_n)) begin
                    r_total <= r_total + SPD_SUM_W'(rd_s_spd);
                    r_dacc  <= d_new;
                    r_dsum  <= r_dsum + DSUM_W'(d_new);
                end
                if (r_rd_idx < SCAN_W'(r_lcnt) && rd_l_spd > r_pk_spd) begin
                    r_pk_spd <= rd_l_spd;
                    r_pk_dir <= rd_l_dir;
                end
            end
        end
        if (r_state == S_MEAN && r_n == '0) begin
            r_mean <= '0;
            r_mdir <= '0;
        end
        if (r_state == S_DIV_MEAN && dv_done) begin
            r_mean <= r_dv_num[SPD_W-1:0];
        end
        if (r_state == S_DIV_DIR && dv_done) begin
            r_mdir <= (dsum_neg && dmod != '0) ? DIR_W'(13'(DIR_FULL) - dmod)
                                               : DIR_W'(dmod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_ispd <= r_now_spd;
            r_o_idir <= r_now_dir;
            r_o_gspd <= r_gust_spd;
            r_o_gdir <= r_gust_dir;
            r_o_mspd <= r_mean;
            r_o_mdir <= r_mdir;
            r_o_pspd <= r_pk_spd;
            r_o_pdir <= r_pk_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_instant_speed = r_o_ispd;
    assign o_instant_dir   = r_o_idir;
    assign o_gust_speed    = r_o_gspd;
    assign o_gust_dir      = r_o_gdir;
    assign o_mean_speed    = r_o_mspd;
    assign o_mean_dir      = r_o_mdir;
    assign o_peak_speed    = r_o_pspd;
    assign o_peak_dir      = r_o_pdir;

`ifndef SYNTHESIS
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("Result beat raised outside the output step.");
    a_lcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcnt <= LCNT_W'(LONG_DEPTH))
        else $error("Long ring fill count past its depth.");
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_cnt != '0) |-> (r_state == S_DIV_SPD || r_state == S_DIV_MEAN ||
                              r_state == S_DIV_DIR))
        else $error("Divider running outside a divide step.");
    a_store_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE) |=> (r_state == S_IDLE))
        else $error("Sample store did not return to idle.");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the wind speed and direction statistics block.
// Predicts each report from sample beats and compares it with the block's output.
// Depends on wsds_pkg and wind_speed_direction_statistics_top.
`timescale 1ns / 100ps

module tb_top;
    import wsds_pkg::*;

    localparam bit REQ_SAMPLE = 1'b0;
    localparam bit REQ_REPORT = 1'b1;
    localparam int LIMIT_CYCLES = 3000000;

    typedef struct packed {
        logic        req;
        logic [15:0] pulses;
        logic [15:0] ms;
        logic [11:0] adc;
    } t_wind_req;

    typedef struct packed {
        logic [15:0] inst_s;
        logic [11:0] inst_d;
        logic [15:0] gust_s;
        logic [11:0] gust_d;
        logic [15:0] mean_s;
        logic [11:0] mean_d;
        logic [15:0] peak_s;
        logic [11:0] peak_d;
    } t_report;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [1:0] paddr = ADDR_SCALE;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 0;
    logic o_in_stall;
    logic i_req_type = 0;
    logic [15:0] i_pulse_count = 0, i_elapsed_ms = 0;
    logic [11:0] i_vane_adc = 0;
    logic o_out_valid;
    logic i_out_stall = 0;
    logic [15:0] o_instant_speed, o_gust_speed, o_mean_speed, o_peak_speed;
    logic [11:0] o_instant_dir, o_gust_dir, o_mean_dir, o_peak_dir;

    wind_speed_direction_statistics_top dut (.*);

    always #1 i_clk = ~i_clk;

    t_wind_req pending_reqs[$];
    t_report expected_reports[$];
    int errors = 0;
    int reports_seen = 0;
    int samples_sent = 0;
    int reports_sent = 0;
    longint cycles = 0;
    int in_gap = 0;
    int out_gap = 0;

    logic [15:0] scale_reg;
    logic [15:0] now_s, gust_s;
    logic [11:0] now_d, gust_d;
    logic [15:0] sring_s[SHORT_DEPTH];
    logic [11:0] sring_d[SHORT_DEPTH];
    logic [15:0] lring_s[LONG_DEPTH];
    logic [11:0] lring_d[LONG_DEPTH];
    int spos, lpos;
    bit sfull;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [15:0] wind_speed(logic [15:0] p, logic [15:0] ms);
        longint unsigned v;
        if (ms == 0) return 16'hFFFF;
        v = (longint'(p) * scale_reg * 100) / ms;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [11:0] vane_heading(logic [11:0] adc);
        int lim[16] = '{273, 345, 382, 516, 748, 989, 1159, 1633,
                        1855, 2408, 2530, 2821, 3153, 3320, 3558, 3790};
        int val[16] = '{1125, 675, 900, 1575, 1350, 2025, 1800, 225,
                        450, 2475, 2250, 3375, 3600, 2925, 3150, 2700};
        for (int i = 0; i < 16; i++)
            if (adc < lim[i]) return 12'(val[i]);
        return '0;
    endfunction

    function automatic logic [11:0] mitsuta_dir(int n);
        longint sum, d, delta, q, m;
        if (n == 0) return '0;
        d = sring_d[0];
        sum = d;
        for (int a = 1; a < n; a++) begin
            delta = longint'(sring_d[a]) - d;
            if (delta < -1800) d += delta + 3600;
            else if (delta > 1800) d += delta - 3600;
            else d += delta;
            sum += d;
        end
        q = sum / n;
        if ((sum % n) < 0) q -= 1;
        m = q % 3600;
        if (m < 0) m += 3600;
        return m[11:0];
    endfunction

    task automatic wind_predict(t_wind_req r);
        t_report e;
        int n;
        longint total;
        if (r.req == REQ_SAMPLE) begin
            now_s = wind_speed(r.pulses, r.ms);
            now_d = vane_heading(r.adc);
            if (now_s > gust_s) begin
                gust_s = now_s;
                gust_d = now_d;
            end
            sring_s[spos] = now_s;
            sring_d[spos] = now_d;
            spos++;
            if (spos >= SHORT_DEPTH) begin
                spos = 0;
                sfull = 1;
            end
            lring_s[lpos] = now_s;
            lring_d[lpos] = now_d;
            lpos = (lpos + 1) % LONG_DEPTH;
            return;
        end
        n = sfull ? SHORT_DEPTH : spos;
        total = 0;
        for (int a = 0; a < n; a++) total += sring_s[a];
        e.mean_s = (n > 0) ? 16'(total / n) : 16'd0;
        e.peak_s = 0;
        e.peak_d = 0;
        for (int a = 0; a < LONG_DEPTH; a++)
            if (lring_s[a] > e.peak_s) begin
                e.peak_s = lring_s[a];
                e.peak_d = lring_d[a];
            end
        e.inst_s = now_s;
        e.inst_d = now_d;
        e.gust_s = gust_s;
        e.gust_d = gust_d;
        e.mean_d = mitsuta_dir(n);
        expected_reports.push_back(e);
        now_s = 0;
        now_d = 0;
        gust_s = 0;
        gust_d = 0;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR report %0d: %s got %0d expected %0d", reports_seen, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Driver: holds each beat until accepted, inserting random gaps between beats.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                wind_predict({i_req_type, i_pulse_count, i_elapsed_ms, i_vane_adc});
                if (i_req_type == REQ_SAMPLE) samples_sent++;
                else reports_sent++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 0;
                end else if (pending_reqs.size() > 0) begin
                    t_wind_req r;
                    r = pending_reqs.pop_front();
                    i_in_valid <= 1;
                    i_req_type <= r.req;
                    i_pulse_count <= r.pulses;
                    i_elapsed_ms <= r.ms;
                    i_vane_adc <= r.adc;
                    in_gap <= rand_gap();
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // Monitor: random output stalls and field-by-field comparison.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    t_report e;
                    e = expected_reports.pop_front();
                    if (o_instant_speed !== e.inst_s)
                        report_mismatch("instant_speed", o_instant_speed, e.inst_s);
                    if (o_instant_dir !== e.inst_d)
                        report_mismatch("instant_dir", o_instant_dir, e.inst_d);
                    if (o_gust_speed !== e.gust_s)
                        report_mismatch("gust_speed", o_gust_speed, e.gust_s);
                    if (o_gust_dir !== e.gust_d)
                        report_mismatch("gust_dir", o_gust_dir, e.gust_d);
                    if (o_mean_speed !== e.mean_s)
                        report_mismatch("mean_speed", o_mean_speed, e.mean_s);
                    if (o_mean_dir !== e.mean_d)
                        report_mismatch("mean_dir", o_mean_dir, e.mean_d);
                    if (o_peak_speed !== e.peak_s)
                        report_mismatch("peak_speed", o_peak_speed, e.peak_s);
                    if (o_peak_dir !== e.peak_d)
                        report_mismatch("peak_dir", o_peak_dir, e.peak_d);
                end
                reports_seen++;
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_stall <= 1;
            end else begin
                i_out_stall <= 0;
                out_gap <= rand_gap();
            end
        end
    end

    task automatic push_req(bit req, logic [15:0] p, logic [15:0] ms, logic [11:0] adc);
        t_wind_req r;
        r.req = req;
        r.pulses = p;
        r.ms = ms;
        r.adc = adc;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_in_valid || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (800) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [15:0] v);
        @(posedge i_clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= ADDR_SCALE;
        pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        scale_reg = v;
    endtask

    task automatic random_phase(int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                push_req(REQ_REPORT, 16'($urandom), 16'($urandom), 12'($urandom));
            end else if (r < 70) begin
                push_req(REQ_SAMPLE, 16'($urandom_range(0, 60)),
                         16'($urandom_range(900, 1100)), 12'($urandom_range(0, 4095)));
            end else begin
                push_req(REQ_SAMPLE, 16'($urandom),
                         ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                         12'($urandom));
            end
        end
    endtask

    initial begin
        scale_reg = SCALE_RESET;
        now_s = 0; now_d = 0; gust_s = 0; gust_d = 0;
        spos = 0; lpos = 0; sfull = 0;
        for (int a = 0; a < LONG_DEPTH; a++) begin
            lring_s[a] = 0;
            lring_d[a] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        push_req(REQ_REPORT, 0, 0, 0);
        push_req(REQ_SAMPLE, 0, 1000, 0);
        push_req(REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 12'hFFF);
        push_req(REQ_SAMPLE, 5, 0, 3789);
        push_req(REQ_SAMPLE, 5, 1000, 3790);
        push_req(REQ_SAMPLE, 5, 1000, 272);
        push_req(REQ_SAMPLE, 5, 1000, 273);
        push_req(REQ_SAMPLE, 3, 1000, 3200);
        push_req(REQ_SAMPLE, 3, 1000, 1700);
        push_req(REQ_REPORT, 16'hFFFF, 16'hFFFF, 12'hFFF);
        push_req(REQ_REPORT, 0, 0, 0);
        wait_drained();

        write_scale(16'd1);
        push_req(REQ_SAMPLE, 1, 16'hFFFF, 100);
        push_req(REQ_SAMPLE, 16'hFFFF, 1, 2000);
        push_req(REQ_REPORT, 0, 0, 0);
        random_phase(200);
        wait_drained();

        write_scale(16'hFFFF);
        random_phase(200);
        wait_drained();

        write_scale(SCALE_RESET);
        random_phase(430);
        push_req(REQ_REPORT, 0, 0, 0);
        wait_drained();

        $display("Covered %0d samples and %0d reports over four scale settings.",
                 samples_sent, reports_sent);
        $display("Checked %0d report beats, %0d errors.", reports_seen, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### wind_speed_direction_statistics_top.f
design/wsds_pkg.sv
design/wind_speed_direction_statistics_top.sv
tb/tb_top.sv
